// File: rtl/core/fsp_pkg.sv
// fsp_pkg: shared constants and types of the format specifier parser
`default_nettype none
package fsp_pkg;

  localparam int FSP_COUNT_BITS = 31;
  localparam int OUT_W          = 31;
  localparam int TDATA_W        = 80;

  // parser phases
  localparam logic [2:0] PH_DONE        = 3'd0;
  localparam logic [2:0] PH_FLAGS       = 3'd1;
  localparam logic [2:0] PH_WIDTH       = 3'd2;
  localparam logic [2:0] PH_PREC_START  = 3'd3;
  localparam logic [2:0] PH_PREC_DIGITS = 3'd4;
  localparam logic [2:0] PH_LENMOD      = 3'd5;
  localparam logic [2:0] PH_PENDING     = 3'd6;

  // pending one-letter modifier
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_H    = 2'd1;
  localparam logic [1:0] PEND_L    = 2'd2;

  // length kinds
  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_HH   = 4'd1;
  localparam logic [3:0] LEN_H    = 4'd2;
  localparam logic [3:0] LEN_LL   = 4'd3;
  localparam logic [3:0] LEN_L    = 4'd4;
  localparam logic [3:0] LEN_J    = 4'd5;
  localparam logic [3:0] LEN_Z    = 4'd6;
  localparam logic [3:0] LEN_BIG_L = 4'd7;
  localparam logic [3:0] LEN_T    = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EOS      = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_J  = 8'h6A;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  // small control state carried between top and step logic
  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] flags;
    logic [1:0] pending;
    logic       star;
  } fsp_ctrl_t;

  typedef struct packed {
    logic [4:0]       flag_bits;
    logic [OUT_W-1:0] field_width;
    logic [OUT_W-1:0] precision_value;
    logic             precision_from_argument;
    logic [3:0]       length_kind;
    logic [1:0]       parse_status;
    logic             char_consumed;
  } fsp_result_t;

endpackage
`default_nettype wire

// File: rtl/core/format_spec_parser.sv
// format_spec_parser: top level of the printf format specifier parser
// output: a result is registered and appears on out in the cycle after the input transfer that ends the spec
// throughput: one input transfer per cycle while out is not stalled; the parse state and the output register
//   are the only stored elements, with one times-ten add between them
// reset: synchronous active-low rst_n clears the parse state to done and empties out
`default_nettype none
module format_spec_parser import fsp_pkg::*; #(
  parameter int COUNT_BITS = FSP_COUNT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] char_code
  input  wire logic               in_tuser,   // [0] first_char
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [4:0] flag_bits, [35:5] field_width, [66:36] precision_value,
  // [67] precision_from_argument, [71:68] length_kind, [73:72] parse_status,
  // [74] char_consumed, [79:75] zero
  output logic [TDATA_W-1:0]      out_tdata
);

  fsp_ctrl_t             ctrl_r;
  fsp_ctrl_t             ctrl_nxt;
  logic [COUNT_BITS-1:0] width_r;
  logic [COUNT_BITS-1:0] width_nxt;
  logic [COUNT_BITS-1:0] prec_r;
  logic [COUNT_BITS-1:0] prec_nxt;
  logic                  res_valid;
  fsp_result_t           res;
  fsp_result_t           out_res_r;
  logic                  out_valid_r;
  logic                  in_xfer;

  // take a new byte whenever the output register is empty or draining this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  fsp_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .char_code  (in_tdata),
    .first_char (in_tuser),
    .ctrl       (ctrl_r),
    .width_acc  (width_r),
    .prec_acc   (prec_r),
    .ctrl_nxt   (ctrl_nxt),
    .width_nxt  (width_nxt),
    .prec_nxt   (prec_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  // parse state, updated once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase   <= PH_DONE;
      ctrl_r.flags   <= '0;
      ctrl_r.pending <= PEND_NONE;
      ctrl_r.star    <= 1'b0;
      width_r        <= '0;
      prec_r         <= '1;
    end else if (in_xfer) begin
      ctrl_r  <= ctrl_nxt;
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
    end
  end

  // output register: loads on a byte that ends the spec, clears when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0,
                       out_res_r.char_consumed,
                       out_res_r.parse_status,
                       out_res_r.length_kind,
                       out_res_r.precision_from_argument,
                       out_res_r.precision_value,
                       out_res_r.field_width,
                       out_res_r.flag_bits};

endmodule
`default_nettype wire

// File: rtl/core/fsp_digit_acc.sv
// fsp_digit_acc: times-ten plus digit with overflow detection
`default_nettype none
module fsp_digit_acc import fsp_pkg::*; #(
  parameter int COUNT_BITS = FSP_COUNT_BITS
) (
  input  wire logic [COUNT_BITS-1:0] acc,
  input  wire logic [3:0]            digit,
  output logic      [COUNT_BITS-1:0] sum,
  output logic      [COUNT_BITS-1:0] times10,
  output logic                       big10,
  output logic                       ovf
);

  localparam int WIDE = COUNT_BITS + 4;

  logic [WIDE-1:0] acc_w;
  logic [WIDE-1:0] t10_w;
  logic [WIDE-1:0] sum_w;

  assign acc_w   = {4'b0, acc};
  assign t10_w   = (acc_w << 3) + (acc_w << 1);
  assign sum_w   = t10_w + {{(WIDE-4){1'b0}}, digit};
  assign times10 = t10_w[COUNT_BITS-1:0];
  assign sum     = sum_w[COUNT_BITS-1:0];
  // above the limit once any bit beyond the count width is set
  assign big10   = |t10_w[WIDE-1:COUNT_BITS];
  assign ovf     = |sum_w[WIDE-1:COUNT_BITS];

endmodule
`default_nettype wire

// File: rtl/core/fsp_step.sv
// fsp_step: next-state and result logic for one format byte
`default_nettype none
module fsp_step import fsp_pkg::*; #(
  parameter int COUNT_BITS = FSP_COUNT_BITS
) (
  input  wire logic [7:0]            char_code,
  input  wire logic                  first_char,
  input  wire fsp_ctrl_t             ctrl,
  input  wire logic [COUNT_BITS-1:0] width_acc,
  input  wire logic [COUNT_BITS-1:0] prec_acc,
  output fsp_ctrl_t                  ctrl_nxt,
  output logic      [COUNT_BITS-1:0] width_nxt,
  output logic      [COUNT_BITS-1:0] prec_nxt,
  output logic                       res_valid,
  output fsp_result_t                res
);

  fsp_ctrl_t             cs;
  logic [COUNT_BITS-1:0] wacc;
  logic [COUNT_BITS-1:0] pacc;
  logic [COUNT_BITS-1:0] acc_in;
  logic [COUNT_BITS-1:0] acc_sum;
  logic [COUNT_BITS-1:0] acc_t10;
  logic [COUNT_BITS-1:0] ovf_val;
  logic                  acc_big;
  logic                  acc_ovf;
  logic [3:0]            dig_diff;
  logic                  is_dig;
  logic                  stop;
  logic [3:0]            kind;
  logic [1:0]            status;
  logic                  used;
  logic [4:0]            flag_hit;
  logic [OUT_W-1:0]      width_out;
  logic [OUT_W-1:0]      prec_out;

  assign dig_diff = 4'(char_code - CH_ZERO);
  assign is_dig   = char_code inside {[CH_ZERO:CH_NINE]};

  // the accumulator that a digit lands in depends on the entry phase
  always_comb begin
    if (first_char || ctrl.phase == PH_FLAGS || ctrl.phase == PH_WIDTH) begin
      acc_in = first_char ? '0 : width_acc;
    end else if (ctrl.phase == PH_PREC_START) begin
      acc_in = '0;
    end else begin
      acc_in = prec_acc;
    end
  end

  fsp_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_acc (
    .acc     (acc_in),
    .digit   (dig_diff),
    .sum     (acc_sum),
    .times10 (acc_t10),
    .big10   (acc_big),
    .ovf     (acc_ovf)
  );

  // value left in the accumulator when a digit overflows
  assign ovf_val = acc_big ? acc_in : acc_t10;

  always_comb begin
    case (char_code)
      CH_MINUS: flag_hit = 5'b00001;
      CH_ZERO:  flag_hit = 5'b00010;
      CH_HASH:  flag_hit = 5'b00100;
      CH_PLUS:  flag_hit = 5'b01000;
      CH_SPACE: flag_hit = 5'b10000;
      default:  flag_hit = 5'b00000;
    endcase
  end

  always_comb begin
    if (first_char) begin
      cs.phase   = PH_FLAGS;
      cs.flags   = '0;
      cs.pending = PEND_NONE;
      cs.star    = 1'b0;
      wacc       = '0;
      pacc       = '1;
    end else begin
      cs   = ctrl;
      wacc = width_acc;
      pacc = prec_acc;
    end
    stop      = (cs.phase == PH_DONE);
    res_valid = 1'b0;
    kind      = LEN_NONE;
    status    = ST_OK;
    used      = 1'b0;

    if (!stop && cs.phase == PH_FLAGS) begin
      if (char_code == CH_NUL) begin
        res_valid = 1'b1;
        status    = ST_EOS;
        stop      = 1'b1;
      end else if (|flag_hit) begin
        cs.flags = cs.flags | flag_hit;
        if (cs.flags[0]) cs.flags[1] = 1'b0;
        if (cs.flags[3]) cs.flags[4] = 1'b0;
        stop = 1'b1;
      end else begin
        cs.phase = PH_WIDTH;
      end
    end

    if (!stop && cs.phase == PH_WIDTH) begin
      if (is_dig) begin
        if (acc_ovf) begin
          wacc      = ovf_val;
          res_valid = 1'b1;
          status    = ST_OVERFLOW;
          used      = 1'b1;
        end else begin
          wacc = acc_sum;
        end
        stop = 1'b1;
      end else if (char_code == CH_NUL) begin
        res_valid = 1'b1;
        status    = ST_EOS;
        stop      = 1'b1;
      end else if (char_code == CH_DOT) begin
        cs.phase = PH_PREC_START;
        stop     = 1'b1;
      end else begin
        cs.phase = PH_LENMOD;
      end
    end

    if (!stop && cs.phase == PH_PREC_START) begin
      if (char_code == CH_STAR) begin
        cs.star  = 1'b1;
        cs.phase = PH_LENMOD;
        stop     = 1'b1;
      end else begin
        pacc     = '0;
        cs.phase = PH_PREC_DIGITS;
      end
    end

    if (!stop && cs.phase == PH_PREC_DIGITS) begin
      if (is_dig) begin
        if (acc_ovf) begin
          pacc      = ovf_val;
          res_valid = 1'b1;
          status    = ST_OVERFLOW;
          used      = 1'b1;
        end else begin
          pacc = acc_sum;
        end
        stop = 1'b1;
      end else if (char_code == CH_NUL) begin
        res_valid = 1'b1;
        status    = ST_EOS;
        stop      = 1'b1;
      end else begin
        cs.phase = PH_LENMOD;
      end
    end

    if (!stop && cs.phase == PH_LENMOD) begin
      stop = 1'b1;
      case (char_code)
        CH_LOW_H: begin
          cs.pending = PEND_H;
          cs.phase   = PH_PENDING;
        end
        CH_LOW_L: begin
          cs.pending = PEND_L;
          cs.phase   = PH_PENDING;
        end
        CH_LOW_J: begin
          res_valid = 1'b1;
          kind      = LEN_J;
          used      = 1'b1;
        end
        CH_LOW_Z: begin
          res_valid = 1'b1;
          kind      = LEN_Z;
          used      = 1'b1;
        end
        CH_UP_L: begin
          res_valid = 1'b1;
          kind      = LEN_BIG_L;
          used      = 1'b1;
        end
        CH_LOW_T: begin
          res_valid = 1'b1;
          kind      = LEN_T;
          used      = 1'b1;
        end
        default: begin
          res_valid = 1'b1;
        end
      endcase
    end

    if (!stop && cs.phase == PH_PENDING) begin
      stop      = 1'b1;
      res_valid = 1'b1;
      if (cs.pending == PEND_H) begin
        used = (char_code == CH_LOW_H);
        kind = used ? LEN_HH : LEN_H;
      end else begin
        used = (char_code == CH_LOW_L);
        kind = used ? LEN_LL : LEN_L;
      end
      cs.pending = PEND_NONE;
    end

    // unused phase code falls back to done
    if (!stop) begin
      cs.phase = PH_DONE;
    end
    if (res_valid) begin
      cs.phase = PH_DONE;
    end
  end

  generate
    if (COUNT_BITS >= OUT_W) begin : g_trunc
      assign width_out = wacc[OUT_W-1:0];
      assign prec_out  = pacc[OUT_W-1:0];
    end else begin : g_ext
      assign width_out = {{(OUT_W-COUNT_BITS){1'b0}}, wacc};
      assign prec_out  = {{(OUT_W-COUNT_BITS){1'b0}}, pacc};
    end
  endgenerate

  assign ctrl_nxt  = cs;
  assign width_nxt = wacc;
  assign prec_nxt  = pacc;

  assign res.flag_bits               = cs.flags;
  assign res.field_width             = width_out;
  assign res.precision_value         = prec_out;
  assign res.precision_from_argument = cs.star;
  assign res.length_kind             = kind;
  assign res.parse_status            = status;
  assign res.char_consumed           = used;

endmodule
`default_nettype wire

// File: rtl/core/fsp_checker.sv
// fsp_checker: port-level checks of the parser, bound to the top level
`default_nettype none
module fsp_checker import fsp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic [7:0]         in_tdata,
  input wire logic               in_tuser,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty output register never stalls the input side
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a nul right after the percent sign ends the spec with end-of-string
  a_first_nul: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && in_tdata == CH_NUL
    |=> out_tvalid && out_tdata[73:72] == ST_EOS && !out_tdata[74])
    else $error("nul after start did not give end-of-string");

  // a length modifier is reported only on a clean parse
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71:68] != LEN_NONE |-> out_tdata[73:72] == ST_OK)
    else $error("length kind with error status");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (.*);
`default_nettype wire
